/* rtl/core/clw_pkg.sv */
`default_nettype none

package clw_pkg;

  // request kinds
  localparam logic [2:0] CMD_COMMAND = 3'd0;
  localparam logic [2:0] CMD_DATA    = 3'd1;
  localparam logic [2:0] CMD_GOTO    = 3'd2;
  localparam logic [2:0] CMD_NUMBER  = 3'd3;
  localparam logic [2:0] CMD_INIT    = 3'd4;
  localparam logic [2:0] CMD_CLEAR   = 3'd5;

  localparam logic [15:0] HOLD_RESET = 16'd50000;
  localparam logic [16:0] NUM_CAP    = 17'd99999;
  localparam logic [7:0]  ASCII_ZERO = 8'h30;
  localparam logic [7:0]  LINE_ONE   = 8'h80;
  localparam logic [7:0]  LINE_TWO   = 8'h40;
  localparam logic [7:0]  LCD_CLEAR  = 8'h01;

  typedef struct packed {
    logic capture;
    logic digit_step;
    logic byte_load;
    logic timer_load;
    logic half_set;
    logic index_inc;
  } clw_cmd_t;

  typedef struct packed {
    logic req_empty;
    logic rem_ge_div;
    logic timer_done;
    logic half;
    logic last_byte;
  } clw_stat_t;

  function automatic logic [16:0] pow10(input logic [2:0] idx);
    logic [16:0] r;
    case (idx)
      3'd0:    r = 17'd10000;
      3'd1:    r = 17'd1000;
      3'd2:    r = 17'd100;
      3'd3:    r = 17'd10;
      default: r = 17'd1;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h03;
      3'd1:    r = 8'h02;
      3'd2:    r = 8'h28;
      3'd3:    r = 8'h0C;
      3'd4:    r = 8'h06;
      default: r = 8'h01;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] byte_count(input logic [2:0] kind);
    logic [2:0] r;
    case (kind)
      CMD_NUMBER: r = 3'd5;
      CMD_INIT:   r = 3'd6;
      CMD_CLEAR:  r = 3'd2;
      default:    r = 3'd1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/clw_datapath.sv */
`default_nettype none

module clw_datapath #(
  parameter int LINES   = 2,
  parameter int COLUMNS = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire  [15:0]         cfg_wdata_i,
  input  wire  [2:0]          cmd_i,
  input  wire  [7:0]          byte_value_i,
  input  wire  [7:0]          row_i,
  input  wire  [7:0]          col_i,
  input  wire  [16:0]         number_i,
  input  clw_pkg::clw_cmd_t   cmd_d_i,
  output clw_pkg::clw_stat_t  stat_o,
  output logic                register_select_o,
  output logic [3:0]          nibble_o,
  output logic                last_o
);

  logic [15:0] hold_q;
  logic [2:0]  kind_q;
  logic [7:0]  bv_q;
  logic [7:0]  pos_q;
  logic [2:0]  idx_q;
  logic [16:0] rem_q;
  logic [3:0]  digit_q;
  logic [7:0]  byte_q;
  logic        half_q;
  logic [15:0] timer_q;

  logic [7:0]  pos_d;
  logic [7:0]  col_off;
  logic [16:0] div;
  logic [7:0]  byte_sel;
  logic        last_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= clw_pkg::HOLD_RESET;
    end else if (cfg_we_i) begin
      hold_q <= cfg_wdata_i;
    end
  end

  // goto address: line base plus column, out-of-range column goes to column 0
  assign col_off = (col_i < 8'(COLUMNS)) ? col_i : 8'h00;
  assign pos_d   = (clw_pkg::LINE_ONE | (row_i[0] ? clw_pkg::LINE_TWO : 8'h00)) + col_off;

  assign div = clw_pkg::pow10(idx_q);

  always_comb begin
    case (kind_q)
      clw_pkg::CMD_COMMAND: byte_sel = bv_q;
      clw_pkg::CMD_DATA:    byte_sel = bv_q;
      clw_pkg::CMD_GOTO:    byte_sel = pos_q;
      clw_pkg::CMD_NUMBER:  byte_sel = clw_pkg::ASCII_ZERO + {4'h0, digit_q};
      clw_pkg::CMD_INIT:    byte_sel = clw_pkg::init_byte(idx_q);
      default:              byte_sel = (idx_q == 3'd0) ? clw_pkg::LCD_CLEAR : clw_pkg::LINE_ONE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_d_i.capture) begin
      kind_q  <= cmd_i;
      bv_q    <= byte_value_i;
      pos_q   <= pos_d;
      idx_q   <= 3'd0;
      rem_q   <= (number_i > clw_pkg::NUM_CAP) ? clw_pkg::NUM_CAP : number_i;
      digit_q <= 4'd0;
    end else begin
      if (cmd_d_i.digit_step) begin
        rem_q   <= rem_q - div;
        digit_q <= digit_q + 4'd1;
      end
      if (cmd_d_i.byte_load) begin
        byte_q  <= byte_sel;
        half_q  <= 1'b0;
        digit_q <= 4'd0;
      end
      if (cmd_d_i.half_set) begin
        half_q <= 1'b1;
      end
      if (cmd_d_i.index_inc) begin
        idx_q <= idx_q + 3'd1;
      end
    end
    if (cmd_d_i.timer_load) begin
      timer_q <= hold_q;
    end else begin
      timer_q <= timer_q - 16'd1;
    end
  end

  assign last_byte = (idx_q == (clw_pkg::byte_count(kind_q) - 3'd1));

  always_comb begin
    stat_o.req_empty  = (cmd_i > clw_pkg::CMD_CLEAR) ||
                        ((cmd_i == clw_pkg::CMD_GOTO) && (row_i >= 8'(LINES)));
    stat_o.rem_ge_div = (kind_q == clw_pkg::CMD_NUMBER) && (rem_q >= div);
    stat_o.timer_done = (timer_q == 16'd1);
    stat_o.half       = half_q;
    stat_o.last_byte  = last_byte;
  end

  assign register_select_o = (kind_q == clw_pkg::CMD_DATA) || (kind_q == clw_pkg::CMD_NUMBER);
  assign nibble_o          = half_q ? byte_q[3:0] : byte_q[7:4];
  assign last_o            = half_q && last_byte;

endmodule

`default_nettype wire

/* rtl/core/clw_ctrl.sv */
`default_nettype none

module clw_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  input  clw_pkg::clw_stat_t  stat_i,
  output clw_pkg::clw_cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_WAIT,
    ST_SHOW
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !stat_i.req_empty) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_PREP;
        end
      end
      ST_PREP: begin
        // number digits come out by repeated subtraction of the place value
        if (stat_i.rem_ge_div) begin
          cmd_o.digit_step = 1'b1;
        end else begin
          cmd_o.byte_load  = 1'b1;
          cmd_o.timer_load = 1'b1;
          state_d          = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (stat_i.timer_done) begin
          out_valid_d = 1'b1;
          state_d     = ST_SHOW;
        end
      end
      ST_SHOW: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          if (!stat_i.half) begin
            cmd_o.half_set   = 1'b1;
            cmd_o.timer_load = 1'b1;
            state_d          = ST_WAIT;
          end else if (stat_i.last_byte) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.index_inc = 1'b1;
            state_d         = ST_PREP;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* rtl/core/char_lcd_4bit_write_sequencer_unit.sv */
// sequence: each nibble shows when the strobe hold timer, loaded from the hold
//   register, runs out; for numbers the subtract loop finds the digit before the
//   timer is loaded; the low nibble's timer starts once its high nibble is taken
// requests: one at a time (in_stall_o while busy), 2 to 12 nibbles each
// reset: controller idle, no result pending, strobe hold register back to 50000
`default_nettype none

module char_lcd_4bit_write_sequencer_unit #(
  parameter int LINES   = 2,
  parameter int COLUMNS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [15:0] cfg_wdata_i,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [2:0]  cmd_i,
  input  wire  [7:0]  byte_value_i,
  input  wire  [7:0]  row_i,
  input  wire  [7:0]  col_i,
  input  wire  [16:0] number_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic        register_select_o,
  output logic [3:0]  nibble_o,
  output logic        last_o
);

  clw_pkg::clw_cmd_t  dp_cmd;
  clw_pkg::clw_stat_t dp_stat;

  clw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  clw_datapath #(
    .LINES   (LINES),
    .COLUMNS (COLUMNS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .cmd_i             (cmd_i),
    .byte_value_i      (byte_value_i),
    .row_i             (row_i),
    .col_i             (col_i),
    .number_i          (number_i),
    .cmd_d_i           (dp_cmd),
    .stat_o            (dp_stat),
    .register_select_o (register_select_o),
    .nibble_o          (nibble_o),
    .last_o            (last_o)
  );

endmodule

`default_nettype wire

/* sim/testbench.sv */
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 10;
  localparam int LCD_LINES   = 2;
  localparam int LCD_COLUMNS = 16;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int PRINT_LIMIT = 40;
  localparam int END_SETTLE_MAX = 4000;

  // kinds the block ignores
  localparam logic [2:0] CMD_RSVD_LO = 3'd6;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;

  localparam logic [7:0] INIT_SEQ [6] = '{8'h03, 8'h02, 8'h28, 8'h0C, 8'h06, 8'h01};

  typedef struct {
    logic [2:0]  cmd;
    logic [7:0]  byte_value;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [16:0] number;
  } lcd_req_t;

  typedef struct packed {
    logic       rs;
    logic [3:0] nibble;
    logic       last;
  } strobe_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  cmd_i;
  logic [7:0]  byte_value_i;
  logic [7:0]  row_i;
  logic [7:0]  col_i;
  logic [16:0] number_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        register_select_o;
  logic [3:0]  nibble_o;
  logic        last_o;

  strobe_t     pending_strobes[$];
  logic [15:0] strobe_hold;
  int          error_count;
  int          cycle_count;
  int          stall_run;
  bit          no_idle;

  char_lcd_4bit_write_sequencer_unit #(
    .LINES   (LCD_LINES),
    .COLUMNS (LCD_COLUMNS)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cmd_i             (cmd_i),
    .byte_value_i      (byte_value_i),
    .row_i             (row_i),
    .col_i             (col_i),
    .number_i          (number_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .register_select_o (register_select_o),
    .nibble_o          (nibble_o),
    .last_o            (last_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("char_lcd_4bit_write_sequencer_unit test failed");
      $finish;
    end
  end

  // mostly short pauses, now and then a long one
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_LIMIT) $display("mismatch: %s", msg);
    error_count++;
  endtask

  // ---- predictor ----

  function automatic void push_byte(input logic rs, input logic [7:0] b);
    pending_strobes.push_back('{rs: rs, nibble: b[7:4], last: 1'b0});
    pending_strobes.push_back('{rs: rs, nibble: b[3:0], last: 1'b0});
  endfunction

  function automatic void predict_strobes(input lcd_req_t req);
    int        before_cnt;
    int        value;
    int        div;
    logic [7:0] pos;
    before_cnt = pending_strobes.size();
    case (req.cmd)
      clw_pkg::CMD_COMMAND: push_byte(1'b0, req.byte_value);
      clw_pkg::CMD_DATA:    push_byte(1'b1, req.byte_value);
      clw_pkg::CMD_GOTO: begin
        if (int'(req.row) < LCD_LINES) begin
          pos = clw_pkg::LINE_ONE | (req.row[0] ? clw_pkg::LINE_TWO : 8'h00);
          if (int'(req.col) < LCD_COLUMNS) pos = pos + req.col;
          push_byte(1'b0, pos);
        end
      end
      clw_pkg::CMD_NUMBER: begin
        value = (req.number > clw_pkg::NUM_CAP) ? int'(clw_pkg::NUM_CAP)
                                                : int'(req.number);
        div = 10000;
        repeat (5) begin
          push_byte(1'b1, clw_pkg::ASCII_ZERO + 8'(value / div));
          value = value % div;
          div = div / 10;
        end
      end
      clw_pkg::CMD_INIT: foreach (INIT_SEQ[i]) push_byte(1'b0, INIT_SEQ[i]);
      clw_pkg::CMD_CLEAR: begin
        push_byte(1'b0, clw_pkg::LCD_CLEAR);
        push_byte(1'b0, clw_pkg::LINE_ONE);
      end
      default: ;
    endcase
    if (pending_strobes.size() > before_cnt)
      pending_strobes[pending_strobes.size() - 1].last = 1'b1;
  endfunction

  // ---- result side ----

  always @(posedge clk_i) begin
    if (stall_run > 0) begin
      out_stall_i <= 1'b1;
      stall_run--;
    end else begin
      out_stall_i <= 1'b0;
      if (!no_idle && $urandom_range(0, 3) == 0) stall_run = pick_idle();
    end
  end

  always @(posedge clk_i) begin
    strobe_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_strobes.size() == 0) begin
        report_mismatch($sformatf("unexpected strobe rs=%0b nibble=%h last=%0b",
                                  register_select_o, nibble_o, last_o));
      end else begin
        want = pending_strobes.pop_front();
        if (register_select_o !== want.rs || nibble_o !== want.nibble ||
            last_o !== want.last)
          report_mismatch($sformatf("got rs=%0b nibble=%h last=%0b, want rs=%0b nibble=%h last=%0b",
                                    register_select_o, nibble_o, last_o,
                                    want.rs, want.nibble, want.last));
      end
    end
  end

  // ---- request side ----

  task automatic send_request(input lcd_req_t req);
    int gap;
    gap = pick_idle();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_i        <= req.cmd;
    byte_value_i <= req.byte_value;
    row_i        <= req.row;
    col_i        <= req.col;
    number_i     <= req.number;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_strobes(req);
  endtask

  task automatic send_fields(input logic [2:0] cmd, input logic [7:0] bv,
                             input logic [7:0] row, input logic [7:0] col,
                             input logic [16:0] num);
    lcd_req_t req;
    req = '{cmd: cmd, byte_value: bv, row: row, col: col, number: num};
    send_request(req);
  endtask

  // lets the bus drain, then waits out the enable low time of the last strobe
  task automatic wait_drained(input int settle_cap);
    int settle;
    in_valid_i <= 1'b0;
    while (pending_strobes.size() != 0) @(posedge clk_i);
    settle = 2 * int'(strobe_hold) + 32;
    if (settle > settle_cap) settle = settle_cap;
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_strobe_hold(input logic [15:0] hold);
    wait_drained(CYCLE_LIMIT);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= hold;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    strobe_hold = hold;
  endtask

  function automatic lcd_req_t rand_request();
    lcd_req_t req;
    int k;
    k = $urandom_range(0, 99);
    if (k < 15)      req.cmd = clw_pkg::CMD_COMMAND;
    else if (k < 35) req.cmd = clw_pkg::CMD_DATA;
    else if (k < 55) req.cmd = clw_pkg::CMD_GOTO;
    else if (k < 80) req.cmd = clw_pkg::CMD_NUMBER;
    else if (k < 87) req.cmd = clw_pkg::CMD_INIT;
    else if (k < 94) req.cmd = clw_pkg::CMD_CLEAR;
    else req.cmd = ($urandom_range(0, 1) != 0) ? CMD_RSVD_HI : CMD_RSVD_LO;
    req.byte_value = 8'($urandom);
    req.row = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, LCD_LINES - 1))
                                          : 8'($urandom);
    req.col = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, LCD_COLUMNS - 1))
                                          : 8'($urandom);
    req.number = ($urandom_range(0, 4) != 0) ? 17'($urandom_range(0, 99999))
                                             : 17'($urandom);
    return req;
  endfunction

  // ---- tests ----

  // one request at the reset enable time, before any register write
  task automatic test_reset_hold();
    send_fields(clw_pkg::CMD_COMMAND, 8'h0F, 8'h00, 8'h00, 17'd0);
  endtask

  task automatic test_directed();
    set_strobe_hold(16'd1);
    send_fields(clw_pkg::CMD_COMMAND, 8'h00, 8'h00, 8'h00, 17'd0);
    send_fields(clw_pkg::CMD_COMMAND, 8'hFF, 8'hFF, 8'hFF, 17'h1FFFF);
    send_fields(clw_pkg::CMD_DATA,    8'h00, 8'h00, 8'h00, 17'd0);
    send_fields(clw_pkg::CMD_DATA,    8'hFF, 8'h00, 8'h00, 17'd0);
    send_fields(clw_pkg::CMD_DATA,    8'hA5, 8'h00, 8'h00, 17'd0);
    send_fields(clw_pkg::CMD_GOTO,    8'h00, 8'd0,   8'd0,   17'd0);
    send_fields(clw_pkg::CMD_GOTO,    8'h00, 8'd1,   8'd15,  17'd0);
    // column past the edge falls back to column 0
    send_fields(clw_pkg::CMD_GOTO,    8'h00, 8'd1,   8'd16,  17'd0);
    send_fields(clw_pkg::CMD_GOTO,    8'h00, 8'd0,   8'd255, 17'd0);
    // rows past the last line send nothing
    send_fields(clw_pkg::CMD_GOTO,    8'h00, 8'd2,   8'd3,   17'd0);
    send_fields(clw_pkg::CMD_GOTO,    8'h00, 8'd255, 8'd0,   17'd0);
    send_fields(clw_pkg::CMD_NUMBER,  8'h00, 8'h00, 8'h00, 17'd0);
    send_fields(clw_pkg::CMD_NUMBER,  8'h00, 8'h00, 8'h00, 17'd99999);
    send_fields(clw_pkg::CMD_NUMBER,  8'h00, 8'h00, 8'h00, 17'd100000);
    send_fields(clw_pkg::CMD_NUMBER,  8'h00, 8'h00, 8'h00, 17'h1FFFF);
    send_fields(clw_pkg::CMD_NUMBER,  8'h00, 8'h00, 8'h00, 17'd12345);
    send_fields(clw_pkg::CMD_NUMBER,  8'h00, 8'h00, 8'h00, 17'd7);
    send_fields(clw_pkg::CMD_INIT,    8'h00, 8'h00, 8'h00, 17'd0);
    send_fields(clw_pkg::CMD_CLEAR,   8'h00, 8'h00, 8'h00, 17'd0);
    send_fields(CMD_RSVD_LO,          8'hFF, 8'd0,   8'd0,   17'd5);
    send_fields(CMD_RSVD_HI,          8'hFF, 8'd1,   8'd1,   17'd5);
    send_fields(clw_pkg::CMD_DATA,    8'h3C, 8'h00, 8'h00, 17'd0);
  endtask

  task automatic test_random();
    logic [15:0] holds [6];
    holds = '{16'd1, 16'd3, 16'd1, 16'd8, 16'd2, 16'd17};
    foreach (holds[p]) begin
      set_strobe_hold(holds[p]);
      // one phase runs with no idling on either side
      no_idle = (p == 2);
      repeat (73) send_request(rand_request());
      no_idle = 1'b0;
    end
  endtask

  task automatic test_max_hold();
    set_strobe_hold(16'hFFFF);
    send_fields(clw_pkg::CMD_DATA, 8'h5A, 8'h00, 8'h00, 17'd0);
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    cmd_i        = clw_pkg::CMD_COMMAND;
    byte_value_i = '0;
    row_i        = '0;
    col_i        = '0;
    number_i     = '0;
    out_stall_i  = 1'b0;
    stall_run    = 0;
    no_idle      = 1'b0;
    error_count  = 0;
    cycle_count  = 0;
    strobe_hold  = clw_pkg::HOLD_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_hold();
    test_directed();
    test_random();
    test_max_hold();

    wait_drained(END_SETTLE_MAX);
    if (error_count == 0) begin
      $display("char_lcd_4bit_write_sequencer_unit test passed");
    end else begin
      $display("char_lcd_4bit_write_sequencer_unit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* char_lcd_4bit_write_sequencer_unit.f */
rtl/core/clw_pkg.sv
rtl/core/clw_datapath.sv
rtl/core/clw_ctrl.sv
rtl/core/char_lcd_4bit_write_sequencer_unit.sv
sim/testbench.sv
